// ----- hw/rtl/bhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// Binary heap priority queue package
// Shared types, command codes, constants and the key ordering function.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int unsigned KeyWidth   = 64;
  localparam int unsigned CountWidth = 8;

  typedef logic signed [KeyWidth-1:0] key_t;

  typedef enum logic {
    CMD_OFFER = 1'b0,
    CMD_POLL  = 1'b1
  } cmd_e;

  // -1.0 in Q32.32, returned by a poll of an empty queue
  localparam key_t KeyEmpty = 64'shFFFF_FFFF_0000_0000;
  localparam key_t KeyZero  = '0;

  typedef struct packed {
    cmd_e command;
    key_t key_in;
  } bhpq_req_t;

  typedef struct packed {
    key_t                  key_out;
    logic                  was_empty;
    logic                  was_dropped;
    logic [CountWidth-1:0] count_out;
  } bhpq_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_UP_FIN,
    ST_DN_ROOT,
    ST_DN_LAST,
    ST_DN_LOAD,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP
  } state_e;

  // True when key a belongs above key b under the selected order
  function automatic logic ranks_above(key_t a, key_t b, logic order_max);
    logic res;
    if (order_max) begin
      res = (a > b);
    end else begin
      res = (a < b);
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/bhpq_ram.sv -----
// ----------------------------------------------------------------------------
// Heap store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module bhpq_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  bhpq_pkg::key_t  wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output bhpq_pkg::key_t  rdata_o
);

  bhpq_pkg::key_t mem_q [DEPTH];
  bhpq_pkg::key_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/binary_heap_priority_queue.sv -----
// An offer reads and compares the parent of the hole at each level as it sifts up,
// moving parents down until the key stops or reaches the root; a poll reads the root
// and the last entry, then reads the children of the hole at each level it descends.
// Offer when full and poll when empty answer at once from idle. One item at a time:
// busy is high until the result strobe, and the receiver cannot stall the result.
// Reset empties the queue and selects min order; the store needs no clearing.
// ----------------------------------------------------------------------------
// Binary heap priority queue
// Bounded min/max heap on signed Q32.32 keys, held in one synchronous memory.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                start,
  output logic                busy,
  input  bhpq_pkg::bhpq_req_t req_i,
  output logic                rsp_valid_o,
  output bhpq_pkg::bhpq_rsp_t rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = AW + 2;

  localparam logic [CW-1:0] CountFull = CW'(DEPTH);

  bhpq_pkg::state_e    state_q, state_d;
  logic                order_max_q;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       pos_q, pos_d;
  bhpq_pkg::key_t      key_q, key_d;
  bhpq_pkg::key_t      kout_q, kout_d;
  bhpq_pkg::key_t      lval_q, lval_d;
  logic                lb_q, lb_d;
  logic                rsp_valid_q, rsp_valid_d;
  bhpq_pkg::bhpq_rsp_t rsp_q, rsp_d;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  bhpq_pkg::key_t      mem_wdata;
  logic [AW-1:0]       mem_raddr;
  bhpq_pkg::key_t      mem_rdata;

  logic [AW-1:0]       parent;
  logic [IW-1:0]       left_idx, right_idx, count_ext;
  logic                has_left, has_right;
  logic                lb_now;
  bhpq_pkg::key_t      best_val;

  assign parent    = AW'((pos_q - AW'(1)) >> 1);
  assign left_idx  = {1'b0, pos_q, 1'b1};
  assign right_idx = left_idx + IW'(1);
  assign count_ext = IW'(count_q);
  assign has_left  = (left_idx < count_ext);
  assign has_right = (right_idx < count_ext);
  assign lb_now    = bhpq_pkg::ranks_above(mem_rdata, key_q, order_max_q);
  assign best_val  = lb_q ? lval_q : key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bhpq_pkg::ST_IDLE;
      order_max_q <= 1'b0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        order_max_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    key_q  <= key_d;
    kout_q <= kout_d;
    lval_q <= lval_d;
    lb_q   <= lb_d;
    rsp_q  <= rsp_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    key_d       = key_q;
    kout_d      = kout_q;
    lval_d      = lval_q;
    lb_d        = lb_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = key_q;
    mem_raddr   = parent;

    unique case (state_q)
      bhpq_pkg::ST_IDLE: begin
        if (start) begin
          rsp_d.key_out     = bhpq_pkg::KeyZero;
          rsp_d.was_empty   = 1'b0;
          rsp_d.was_dropped = 1'b0;
          rsp_d.count_out   = bhpq_pkg::CountWidth'(count_q);
          if (req_i.command == bhpq_pkg::CMD_OFFER) begin
            if (count_q >= CountFull) begin
              // drop the key, answer at once
              rsp_d.was_dropped = 1'b1;
              rsp_valid_d       = 1'b1;
            end else begin
              key_d   = req_i.key_in;
              pos_d   = AW'(count_q);
              count_d = count_q + CW'(1);
              state_d = (count_q == '0) ? bhpq_pkg::ST_UP_FIN : bhpq_pkg::ST_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              rsp_d.key_out   = bhpq_pkg::KeyEmpty;
              rsp_d.was_empty = 1'b1;
              rsp_valid_d     = 1'b1;
            end else begin
              count_d = count_q - CW'(1);
              state_d = bhpq_pkg::ST_DN_ROOT;
            end
          end
        end
      end

      bhpq_pkg::ST_UP_RD: begin
        mem_raddr = parent;
        state_d   = bhpq_pkg::ST_UP_CMP;
      end

      bhpq_pkg::ST_UP_CMP: begin
        if (bhpq_pkg::ranks_above(key_q, mem_rdata, order_max_q)) begin
          // move the parent down into the hole
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          pos_d     = parent;
          state_d   = (parent == '0) ? bhpq_pkg::ST_UP_FIN : bhpq_pkg::ST_UP_RD;
        end else begin
          mem_we          = 1'b1;
          rsp_d.count_out = bhpq_pkg::CountWidth'(count_q);
          rsp_valid_d     = 1'b1;
          state_d         = bhpq_pkg::ST_IDLE;
        end
      end

      bhpq_pkg::ST_UP_FIN: begin
        mem_we          = 1'b1;
        rsp_d.count_out = bhpq_pkg::CountWidth'(count_q);
        rsp_valid_d     = 1'b1;
        state_d         = bhpq_pkg::ST_IDLE;
      end

      bhpq_pkg::ST_DN_ROOT: begin
        mem_raddr = '0;
        state_d   = bhpq_pkg::ST_DN_LAST;
      end

      bhpq_pkg::ST_DN_LAST: begin
        // count already holds the index of the last entry
        mem_raddr = AW'(count_q);
        kout_d    = mem_rdata;
        state_d   = bhpq_pkg::ST_DN_LOAD;
      end

      bhpq_pkg::ST_DN_LOAD: begin
        key_d = mem_rdata;
        pos_d = '0;
        if (count_q == '0) begin
          rsp_d.key_out   = kout_q;
          rsp_d.count_out = bhpq_pkg::CountWidth'(count_q);
          rsp_valid_d     = 1'b1;
          state_d         = bhpq_pkg::ST_IDLE;
        end else begin
          state_d = bhpq_pkg::ST_DN_RDL;
        end
      end

      bhpq_pkg::ST_DN_RDL: begin
        mem_raddr = left_idx[AW-1:0];
        if (has_left) begin
          state_d = bhpq_pkg::ST_DN_RDR;
        end else begin
          mem_we          = 1'b1;
          rsp_d.key_out   = kout_q;
          rsp_d.count_out = bhpq_pkg::CountWidth'(count_q);
          rsp_valid_d     = 1'b1;
          state_d         = bhpq_pkg::ST_IDLE;
        end
      end

      bhpq_pkg::ST_DN_RDR: begin
        mem_raddr = right_idx[AW-1:0];
        lval_d    = mem_rdata;
        lb_d      = lb_now;
        if (has_right) begin
          state_d = bhpq_pkg::ST_DN_CMP;
        end else if (lb_now) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          pos_d     = left_idx[AW-1:0];
          state_d   = bhpq_pkg::ST_DN_RDL;
        end else begin
          mem_we          = 1'b1;
          rsp_d.key_out   = kout_q;
          rsp_d.count_out = bhpq_pkg::CountWidth'(count_q);
          rsp_valid_d     = 1'b1;
          state_d         = bhpq_pkg::ST_IDLE;
        end
      end

      bhpq_pkg::ST_DN_CMP: begin
        // right child wins only on a strict compare against the better one
        if (bhpq_pkg::ranks_above(mem_rdata, best_val, order_max_q)) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          pos_d     = right_idx[AW-1:0];
          state_d   = bhpq_pkg::ST_DN_RDL;
        end else if (lb_q) begin
          mem_we    = 1'b1;
          mem_wdata = lval_q;
          pos_d     = left_idx[AW-1:0];
          state_d   = bhpq_pkg::ST_DN_RDL;
        end else begin
          mem_we          = 1'b1;
          rsp_d.key_out   = kout_q;
          rsp_d.count_out = bhpq_pkg::CountWidth'(count_q);
          rsp_valid_d     = 1'b1;
          state_d         = bhpq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bhpq_pkg::ST_IDLE;
      end
    endcase
  end

  bhpq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign busy        = (state_q != bhpq_pkg::ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
